// ----- hw/rtl/nsel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsel_pkg: shared definitions of the lock table
// Defaults, reply kinds and the sequencer states.
// ----------------------------------------------------------------------------
package nsel_pkg;
  localparam int NumLocksDef  = 16;
  localparam int WaitSlotsDef = 16;
  localparam int KeyBitsDef   = 32;
  localparam int TaskBitsDef  = 8;

  localparam int RefW   = 32;
  localparam int OTaskW = 8;
  localparam int IdxW   = 4;
  localparam int NestW  = 8;
  localparam logic [NestW-1:0] NestMax = 8'd255;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_DENY  = 2'd1,
    KIND_ACK   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_FREE,
    ST_DECIDE,
    ST_QSLOT,
    ST_UNLOCK,
    ST_WSCAN,
    ST_WPICK,
    ST_AGE,
    ST_EMIT,
    ST_ACK
  } state_e;
endpackage

// ----- hw/rtl/nested_shared_exclusive_lock_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_shared_exclusive_lock_table_top
// Named reader/writer lock table with nesting and FIFO waiters.
// ----------------------------------------------------------------------------
// One sequencer walks the entry table and the waiter pool one slot per cycle
// with a single compare unit. A request by name searches the keys of all
// entries, a request by index reads its entry directly. A create that misses
// adds a search for a free entry, and a lock that must wait adds a search for
// a free waiter slot. A decide step then decides and loads the reply
// register. An unlock that drops the nest to zero scans the waiter pool;
// each released waiter then costs a reply plus an age update, and a shared
// or destroy release rescans for the next waiter. A reply that is not taken
// stalls the sequencer. The block takes no new item until every reply of the
// current one has been delivered.
module nested_shared_exclusive_lock_table_top #(
  parameter int NUM_LOCKS  = nsel_pkg::NumLocksDef,
  parameter int WAIT_SLOTS = nsel_pkg::WaitSlotsDef,
  parameter int KEY_BITS   = nsel_pkg::KeyBitsDef,
  parameter int TASK_BITS  = nsel_pkg::TaskBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic                        by_name_i,
  input  logic                        create_i,
  input  logic                        shared_i,
  input  logic                        try_only_i,
  input  logic                        destroy_i,
  input  logic [nsel_pkg::RefW-1:0]   atom_ref_i,
  input  logic [nsel_pkg::OTaskW-1:0] task_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nsel_pkg::OTaskW-1:0] reply_task_o,
  output logic [1:0]                  reply_kind_o,
  output logic [nsel_pkg::IdxW-1:0]   atom_index_o,
  output logic                        last_o
);
  import nsel_pkg::*;

  localparam int LW = $clog2(NUM_LOCKS);
  localparam int WW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int LC = $clog2(NUM_LOCKS + 1);
  localparam int WC = $clog2(WAIT_SLOTS + 1);
  localparam int AW = $clog2(WAIT_SLOTS + 1);

  logic [NUM_LOCKS-1:0]  ev_q, lk_q, sh_q;
  logic [KEY_BITS-1:0]   key_q   [NUM_LOCKS];
  logic [TASK_BITS-1:0]  own_q   [NUM_LOCKS];
  logic [NestW-1:0]      nest_q  [NUM_LOCKS];
  logic [WAIT_SLOTS-1:0] wv_q;
  logic [LW-1:0]         we_q    [WAIT_SLOTS];
  logic [TASK_BITS-1:0]  wt_q    [WAIT_SLOTS];
  logic [WAIT_SLOTS-1:0] ws_q;
  logic [AW-1:0]         wa_q    [WAIT_SLOTS];

  state_e state_q, state_d;
  logic unl_q, byn_q, cre_q, shr_q, try_q, des_q;
  logic [KEY_BITS-1:0]  key_r_q;
  logic [RefW-1:0]      ref_q;
  logic [TASK_BITS-1:0] tsk_q;
  logic [LC-1:0] lcnt_q;
  logic [WC-1:0] wcnt_q;
  logic          fnd_q;
  logic [LW-1:0] e_q;
  logic          bfnd_q, only_sh_q;
  logic [WW-1:0] best_q;
  logic [AW-1:0] bage_q;
  logic [AW-1:0] rage_q;
  logic          nxt_emit_q; // after age update: rescan for the next waiter
  logic          ov_q;
  logic [OTaskW-1:0] ot_q;
  kind_e         ok_q;
  logic [IdxW-1:0] oi_q;
  logic          ol_q;

  logic [LW-1:0] li;
  logic [WW-1:0] wi;
  assign li = lcnt_q[LW-1:0];
  assign wi = wcnt_q[WW-1:0];

  assign in_ready_o   = (state_q == ST_IDLE) && !ov_q;
  assign out_valid_o  = ov_q;
  assign reply_task_o = ot_q;
  assign reply_kind_o = ok_q;
  assign atom_index_o = oi_q;
  assign last_o       = ol_q;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;
  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  logic [OTaskW-1:0] tsk_ext;
  assign tsk_ext = OTaskW'(tsk_q);
  logic [IdxW-1:0] e_ext;
  assign e_ext = IdxW'(e_q);

  // The entry was created by this request.
  logic is_new;
  assign is_new = des_q && !cre_q && !byn_q && !unl_q && !try_q
                  && lk_q[e_q] && nest_q[e_q] == NestW'(1)
                  && own_q[e_q] == tsk_q && !sh_q[e_q]
                  && lcnt_q == LC'(NUM_LOCKS);
  logic deny_now;
  assign deny_now = (cre_q && (!byn_q || (fnd_q && try_q))) || !fnd_q;
  logic may_nest;
  assign may_nest = (sh_q[e_q] && shr_q) || (!sh_q[e_q] && own_q[e_q] == tsk_q);

  logic              emit;
  logic [OTaskW-1:0] emit_task;
  kind_e             emit_kind;
  logic [IdxW-1:0]   emit_idx;
  logic              emit_last;
  logic              take_free;
  logic              nest_up;
  logic              queue_req;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_FIND;
      ST_FIND: begin
        if (!byn_q) begin
          state_d = ST_DECIDE;
        end else if (lcnt_q == LC'(NUM_LOCKS)) begin
          state_d = (!unl_q && cre_q && !fnd_q) ? ST_FREE : ST_DECIDE;
        end
      end
      ST_FREE: if (lcnt_q == LC'(NUM_LOCKS)) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free) begin
          if (unl_q) state_d = fnd_q ? ST_UNLOCK : ST_ACK;
          else if (queue_req) state_d = ST_QSLOT;
          else state_d = ST_IDLE;
        end
      end
      ST_QSLOT: if (wcnt_q == WC'(WAIT_SLOTS)) state_d = ST_IDLE;
      ST_UNLOCK: state_d = (nest_q[e_q] > NestW'(1)) ? ST_ACK : ST_WSCAN;
      ST_WSCAN: if (wcnt_q == WC'(WAIT_SLOTS)) state_d = ST_WPICK;
      ST_WPICK: begin
        if (!bfnd_q) state_d = ST_ACK;
        else if (out_free) state_d = ST_AGE;
      end
      ST_AGE: begin
        if (wcnt_q == WC'(WAIT_SLOTS)) state_d = nxt_emit_q ? ST_WSCAN : ST_ACK;
      end
      ST_ACK: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_task = tsk_ext;
    emit_kind = KIND_DENY;
    emit_idx  = '0;
    emit_last = 1'b1;
    take_free = 1'b0;
    nest_up   = 1'b0;
    queue_req = 1'b0;
    unique case (state_q)
      ST_DECIDE: begin
        if (out_free && !unl_q) begin
          priority if (deny_now) begin
            emit = 1'b1;
          end else if (is_new) begin
            emit = 1'b1; emit_kind = KIND_GRANT; emit_idx = e_ext;
          end else if (!lk_q[e_q]) begin
            emit = 1'b1; emit_kind = KIND_GRANT; emit_idx = e_ext;
            take_free = 1'b1;
          end else if (may_nest) begin
            emit = 1'b1;
            if (nest_q[e_q] < NestMax) begin
              emit_kind = KIND_GRANT; emit_idx = e_ext; nest_up = 1'b1;
            end
          end else if (try_q) begin
            emit = 1'b1;
          end else begin
            queue_req = 1'b1;
          end
        end
      end
      ST_QSLOT: emit = (wcnt_q == WC'(WAIT_SLOTS)) && !bfnd_q;
      ST_WPICK: begin
        if (bfnd_q && out_free) begin
          emit = 1'b1;
          emit_task = OTaskW'(wt_q[best_q]);
          emit_last = 1'b0;
          if (!des_q) begin
            emit_kind = KIND_GRANT; emit_idx = e_ext;
          end
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit = 1'b1; emit_kind = KIND_ACK;
          emit_idx = fnd_q ? e_ext : '0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ev_q <= '0; lk_q <= '0; sh_q <= '0; wv_q <= '0;
      for (int i = 0; i < NUM_LOCKS; i++) nest_q[i] <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ov_q <= 1'b1; ot_q <= emit_task; ok_q <= emit_kind;
        oi_q <= emit_idx; ol_q <= emit_last;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unl_q <= func_i; byn_q <= by_name_i; cre_q <= create_i;
            shr_q <= shared_i; try_q <= try_only_i; des_q <= destroy_i;
            ref_q <= atom_ref_i;
            key_r_q <= KEY_BITS'(64'(atom_ref_i));
            tsk_q <= task_id_i[TASK_BITS-1:0];
            lcnt_q <= '0;
            fnd_q <= 1'b0;
            e_q <= '0;
          end
        end
        ST_FIND: begin
          if (!byn_q) begin
            if (ref_q < RefW'(NUM_LOCKS) && ev_q[ref_q[LW-1:0]]) begin
              fnd_q <= 1'b1; e_q <= ref_q[LW-1:0];
            end
            lcnt_q <= '0;
          end else if (lcnt_q == LC'(NUM_LOCKS)) begin
            lcnt_q <= '0;
          end else begin
            if (!fnd_q && ev_q[li] && key_q[li] == key_r_q) begin
              fnd_q <= 1'b1; e_q <= li;
            end
            lcnt_q <= lcnt_q + 1'b1;
          end
        end
        ST_FREE: begin
          if (lcnt_q != LC'(NUM_LOCKS)) begin
            if (!fnd_q && !ev_q[li]) begin
              fnd_q <= 1'b1; e_q <= li;
              ev_q[li] <= 1'b1; key_q[li] <= key_r_q; lk_q[li] <= 1'b1;
              sh_q[li] <= 1'b0; own_q[li] <= tsk_q; nest_q[li] <= NestW'(1);
              cre_q <= 1'b0; // mark: freshly created
              try_q <= 1'b0;
              byn_q <= 1'b0;
              unl_q <= 1'b0;
              des_q <= 1'b1; // reused as created flag
            end
            lcnt_q <= lcnt_q + 1'b1;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            wcnt_q <= '0;
            bfnd_q <= 1'b0;
            if (take_free) begin
              lk_q[e_q] <= 1'b1; sh_q[e_q] <= shr_q;
              own_q[e_q] <= shr_q ? '0 : tsk_q; nest_q[e_q] <= NestW'(1);
            end
            if (nest_up) nest_q[e_q] <= nest_q[e_q] + 1'b1;
          end
        end
        ST_QSLOT: begin
          // find the lowest free waiter slot, then age all others by one
          if (wcnt_q == WC'(WAIT_SLOTS)) begin
            if (bfnd_q) begin
              for (int i = 0; i < WAIT_SLOTS; i++)
                if (wv_q[i]) wa_q[i] <= wa_q[i] + 1'b1;
              wv_q[best_q] <= 1'b1; we_q[best_q] <= e_q; wt_q[best_q] <= tsk_q;
              ws_q[best_q] <= shr_q; wa_q[best_q] <= '0;
            end
          end else begin
            if (!bfnd_q && !wv_q[wi]) begin
              bfnd_q <= 1'b1; best_q <= wi;
            end
            wcnt_q <= wcnt_q + 1'b1;
          end
        end
        ST_UNLOCK: begin
          if (nest_q[e_q] > NestW'(1)) begin
            nest_q[e_q] <= nest_q[e_q] - 1'b1;
          end else begin
            nest_q[e_q] <= '0; lk_q[e_q] <= 1'b0; sh_q[e_q] <= 1'b0;
            own_q[e_q] <= '0;
            only_sh_q <= 1'b0; bfnd_q <= 1'b0; wcnt_q <= '0;
          end
        end
        ST_WSCAN: begin
          if (wcnt_q != WC'(WAIT_SLOTS)) begin
            if (wv_q[wi] && we_q[wi] == e_q && (!only_sh_q || ws_q[wi]) &&
                (!bfnd_q || wa_q[wi] > bage_q)) begin
              bfnd_q <= 1'b1; best_q <= wi; bage_q <= wa_q[wi];
            end
            wcnt_q <= wcnt_q + 1'b1;
          end
        end
        ST_WPICK: begin
          if (!bfnd_q) begin
            if (des_q) ev_q[e_q] <= 1'b0;
          end else if (out_free) begin
            if (!des_q) begin
              lk_q[e_q] <= 1'b1;
              if (!only_sh_q) begin
                nest_q[e_q] <= NestW'(1);
                if (ws_q[best_q]) sh_q[e_q] <= 1'b1;
                else own_q[e_q] <= wt_q[best_q];
              end else begin
                nest_q[e_q] <= nest_q[e_q] + 1'b1;
              end
            end
            rage_q <= bage_q;
            wv_q[best_q] <= 1'b0;
            nxt_emit_q <= des_q || ws_q[best_q] || only_sh_q;
            wcnt_q <= '0;
          end
        end
        ST_AGE: begin
          if (wcnt_q == WC'(WAIT_SLOTS)) begin
            bfnd_q <= 1'b0; wcnt_q <= '0;
            if (nxt_emit_q) only_sh_q <= !des_q;
          end else begin
            if (wv_q[wi] && wa_q[wi] > rage_q) wa_q[wi] <= wa_q[wi] - 1'b1;
            wcnt_q <= wcnt_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ----- hw/rtl/nsel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsel_checker: port-level checks of the lock table
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
module nsel_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] reply_kind_o,
  input logic       last_o
);
  import nsel_pkg::*;

  // A new item is never taken while a reply waits.
  a_no_in_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken with reply pending");

  // An acknowledge is always the final reply.
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reply_kind_o == KIND_ACK) |-> last_o)
    else $error("acknowledge not final");

  // Right after an accepted item the block is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("not busy");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("reply dropped");
endmodule

bind nested_shared_exclusive_lock_table_top nsel_checker u_nsel_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .reply_kind_o(reply_kind_o), .last_o(last_o)
);
